[design/chtp_pkg.sv]
package chtp_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BKT_W  = 6;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_GET    = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_POP    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [ST_W-1:0] ST_NEW      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_CLEARED  = 3'd4;

endpackage

[design/chtp_head_mem.sv]
module chtp_head_mem
  import chtp_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned BW    = 6,
  parameter int unsigned NW    = 6
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [BW-1:0] rd_addr_i,
  output logic          rd_valid_o,
  output logic [NW-1:0] rd_node_o,
  input  logic          we_i,
  input  logic [BW-1:0] waddr_i,
  input  logic          wvalid_i,
  input  logic [NW-1:0] wnode_i
);

  logic [NW:0] mem [DEPTH];
  logic [NW:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wvalid_i, wnode_i};
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_valid_o = rdata_q[NW];
  assign rd_node_o  = rdata_q[NW-1:0];

endmodule

[design/chtp_node_mem.sv]
module chtp_node_mem
  import chtp_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned NW    = 6,
  parameter int unsigned KW    = 32,
  parameter int unsigned VW    = 32
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [NW-1:0]    rd_addr_i,
  output logic [NW-1:0]    rd_link_o,
  output logic [KW-1:0]    rd_key_o,
  output logic [VW-1:0]    rd_val_o,
  output logic [LEN_W-1:0] rd_len_o,
  input  logic             link_we_i,
  input  logic [NW-1:0]    link_waddr_i,
  input  logic [NW-1:0]    link_wdata_i,
  input  logic             data_we_i,
  input  logic [NW-1:0]    data_waddr_i,
  input  logic [KW-1:0]    wr_key_i,
  input  logic [VW-1:0]    wr_val_i,
  input  logic [LEN_W-1:0] wr_len_i
);

  logic [NW-1:0]          link_mem [DEPTH];
  logic [KW+VW+LEN_W-1:0] data_mem [DEPTH];
  logic [NW-1:0]          link_q;
  logic [KW+VW+LEN_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (data_we_i) begin
      data_mem[data_waddr_i] <= {wr_key_i, wr_val_i, wr_len_i};
    end
    if (rd_en_i) begin
      link_q <= link_mem[rd_addr_i];
      data_q <= data_mem[rd_addr_i];
    end
  end

  assign rd_link_o = link_q;
  assign rd_key_o  = data_q[KW+VW+LEN_W-1:VW+LEN_W];
  assign rd_val_o  = data_q[VW+LEN_W-1:LEN_W];
  assign rd_len_o  = data_q[LEN_W-1:0];

endmodule

[design/chained_hash_table_node_pool_unit.sv]
// Key/value store over a fixed pool of nodes chained per hash bucket.
// Input channel: in_valid_i with in_stall_o carries one operation per beat
// (set, get, update, pop or clear) with its bucket, key, value and length.
// Output channel: out_valid_o with out_stall_i returns one result beat per
// operation: status, returned value and length, node slot and key count.
// An operation reads the bucket head, then walks the chain one node per
// cycle through the node memory's single read port. A get or update then
// goes through a decide state to the finish state; a pop adds a state that
// frees the node, and a set that links a new node adds a free-list read
// and, on a non-empty chain, a link from the last node visited. Unknown
// opcodes go straight to the finish state. A clear rewrites the head table
// and the link memory one entry a cycle. After reset the same pass runs
// with in_stall_o high; it gives no result beat.
// One operation is in flight at a time; in_stall_o is low only between
// operations. A finished result waits in the output register while the
// receiver stalls, and the next operation may be accepted meanwhile; it
// then completes once the waiting beat is taken.
module chained_hash_table_node_pool_unit
  import chtp_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 64,
  parameter int unsigned POOL_NODES   = 64,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [BKT_W-1:0]  bucket_i,
  input  logic [KEY_W-1:0]  key_word_i,
  input  logic [VAL_W-1:0]  value_word_i,
  input  logic [LEN_W-1:0]  value_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [VAL_W-1:0]  out_value_o,
  output logic [LEN_W-1:0]  out_length_o,
  output logic [SLOT_W-1:0] node_slot_o,
  output logic [CNT_W-1:0]  stored_count_o
);

  localparam int unsigned BW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned NW   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned CW   = $clog2(POOL_NODES + 1);
  localparam int unsigned KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned VW   = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int unsigned MAXD = (BUCKET_COUNT > POOL_NODES) ? BUCKET_COUNT : POOL_NODES;
  localparam int unsigned SW   = $clog2(MAXD + 1);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_HEAD, S_WALK, S_DECIDE, S_FREERD, S_LINKP, S_POP2, S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [BW-1:0]     bkt_q, bkt_d;
  logic [KW-1:0]     key_q, key_d;
  logic [VW-1:0]     val_q, val_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [NW-1:0]     cur_q, cur_d;
  logic [NW-1:0]     prev_q, prev_d;
  logic              prev_ok_q, prev_ok_d;
  logic              found_q, found_d;
  logic [CW-1:0]     steps_q, steps_d;
  logic [NW-1:0]     free_head_q, free_head_d;
  logic              free_valid_q, free_valid_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SW-1:0]     sweep_q, sweep_d;
  logic              clr_q, clr_d;
  logic [ST_W-1:0]   res_st_q, res_st_d;
  logic [VW-1:0]     res_val_q, res_val_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [NW-1:0]     res_slot_q, res_slot_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic              hd_rd_en, hd_we, hd_wvalid, hd_rd_valid;
  logic [BW-1:0]     hd_rd_addr, hd_waddr;
  logic [NW-1:0]     hd_wnode, hd_rd_node;
  logic              nm_rd_en, nl_we, nd_we;
  logic [NW-1:0]     nm_rd_addr, nl_waddr, nl_wdata, nd_waddr;
  logic [NW-1:0]     nm_rd_link;
  logic [KW-1:0]     nm_rd_key;
  logic [VW-1:0]     nm_rd_val;
  logic [LEN_W-1:0]  nm_rd_len;
  logic [BW-1:0]     bidx;
  logic              last;

  always_comb begin
    bidx = '0;
    for (int k = 0; k < (1 << BKT_W); k++) begin
      if (bucket_i == BKT_W'(k)) begin
        bidx = BW'(k % BUCKET_COUNT);
      end
    end
  end

  chtp_head_mem #(
    .DEPTH (BUCKET_COUNT),
    .BW    (BW),
    .NW    (NW)
  ) u_head (
    .clk_i      (clk_i),
    .rd_en_i    (hd_rd_en),
    .rd_addr_i  (hd_rd_addr),
    .rd_valid_o (hd_rd_valid),
    .rd_node_o  (hd_rd_node),
    .we_i       (hd_we),
    .waddr_i    (hd_waddr),
    .wvalid_i   (hd_wvalid),
    .wnode_i    (hd_wnode)
  );

  chtp_node_mem #(
    .DEPTH (POOL_NODES),
    .NW    (NW),
    .KW    (KW),
    .VW    (VW)
  ) u_node (
    .clk_i        (clk_i),
    .rd_en_i      (nm_rd_en),
    .rd_addr_i    (nm_rd_addr),
    .rd_link_o    (nm_rd_link),
    .rd_key_o     (nm_rd_key),
    .rd_val_o     (nm_rd_val),
    .rd_len_o     (nm_rd_len),
    .link_we_i    (nl_we),
    .link_waddr_i (nl_waddr),
    .link_wdata_i (nl_wdata),
    .data_we_i    (nd_we),
    .data_waddr_i (nd_waddr),
    .wr_key_i     (key_q),
    .wr_val_i     (val_q),
    .wr_len_i     (len_q)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    bkt_d        = bkt_q;
    key_d        = key_q;
    val_d        = val_q;
    len_d        = len_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_ok_d    = prev_ok_q;
    found_d      = found_q;
    steps_d      = steps_q;
    free_head_d  = free_head_q;
    free_valid_d = free_valid_q;
    count_d      = count_q;
    sweep_d      = sweep_q;
    clr_d        = clr_q;
    res_st_d     = res_st_q;
    res_val_d    = res_val_q;
    res_len_d    = res_len_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_st_d     = out_st_q;
    out_val_d    = out_val_q;
    out_len_d    = out_len_q;
    out_slot_d   = out_slot_q;
    out_cnt_d    = out_cnt_q;
    hd_rd_en     = 1'b0;
    hd_rd_addr   = bkt_q;
    hd_we        = 1'b0;
    hd_waddr     = bkt_q;
    hd_wvalid    = 1'b0;
    hd_wnode     = '0;
    nm_rd_en     = 1'b0;
    nm_rd_addr   = cur_q;
    nl_we        = 1'b0;
    nl_waddr     = cur_q;
    nl_wdata     = cur_q;
    nd_we        = 1'b0;
    nd_waddr     = cur_q;
    last         = (nm_rd_link == cur_q);

    unique case (state_q)
      S_SWEEP: begin
        nl_we    = (sweep_q < SW'(POOL_NODES));
        nl_waddr = sweep_q[NW-1:0];
        nl_wdata = (sweep_q == '0) ? '0 : NW'(sweep_q - SW'(1));
        hd_we    = (sweep_q < SW'(BUCKET_COUNT));
        hd_waddr = sweep_q[BW-1:0];
        if (sweep_q == SW'(MAXD - 1)) begin
          res_st_d = ST_CLEARED;
          state_d  = clr_q ? S_FIN : S_IDLE;
        end else begin
          sweep_d = sweep_q + SW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = opcode_i;
          bkt_d      = bidx;
          key_d      = key_word_i[KW-1:0];
          val_d      = value_word_i[VW-1:0];
          len_d      = value_length_i;
          found_d    = 1'b0;
          prev_ok_d  = 1'b0;
          prev_d     = '0;
          steps_d    = '0;
          res_st_d   = ST_NOTFOUND;
          res_val_d  = '0;
          res_len_d  = '0;
          res_slot_d = '0;
          if (opcode_i == OP_CLEAR) begin
            sweep_d      = '0;
            clr_d        = 1'b1;
            free_head_d  = NW'(POOL_NODES - 1);
            free_valid_d = 1'b1;
            count_d      = '0;
            state_d      = S_SWEEP;
          end else if (opcode_i > OP_CLEAR) begin
            state_d = S_FIN;
          end else begin
            hd_rd_en   = 1'b1;
            hd_rd_addr = bidx;
            state_d    = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (hd_rd_valid) begin
          nm_rd_en   = 1'b1;
          nm_rd_addr = hd_rd_node;
          cur_d      = hd_rd_node;
          state_d    = S_WALK;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_WALK: begin
        if (nm_rd_key == key_q) begin
          found_d = 1'b1;
          state_d = S_DECIDE;
        end else begin
          prev_ok_d = 1'b1;
          prev_d    = cur_q;
          if (last || steps_q == CW'(POOL_NODES - 1)) begin
            state_d = S_DECIDE;
          end else begin
            cur_d      = nm_rd_link;
            nm_rd_en   = 1'b1;
            nm_rd_addr = nm_rd_link;
            steps_d    = steps_q + CW'(1);
          end
        end
      end
      S_DECIDE: begin
        state_d = S_FIN;
        case (op_q) inside
          OP_SET: begin
            if (found_q) begin
              nd_we      = 1'b1;
              res_st_d   = ST_FOUND;
              res_slot_d = cur_q;
            end else if (!free_valid_q) begin
              res_st_d = ST_FULL;
            end else begin
              nm_rd_en   = 1'b1;
              nm_rd_addr = free_head_q;
              state_d    = S_FREERD;
            end
          end
          OP_GET, OP_UPDATE, OP_POP: begin
            if (found_q) begin
              res_st_d  = ST_FOUND;
              res_val_d = nm_rd_val;
              res_len_d = nm_rd_len;
              if (op_q == OP_UPDATE) begin
                nd_we = 1'b1;
              end else if (op_q == OP_POP) begin
                if (prev_ok_q) begin
                  nl_we    = 1'b1;
                  nl_waddr = prev_q;
                  nl_wdata = last ? prev_q : nm_rd_link;
                end else begin
                  hd_we     = 1'b1;
                  hd_wvalid = !last;
                  hd_wnode  = nm_rd_link;
                end
                state_d = S_POP2;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_FREERD: begin
        if (nm_rd_link == free_head_q) begin
          free_valid_d = 1'b0;
        end else begin
          free_head_d = nm_rd_link;
        end
        nd_we      = 1'b1;
        nd_waddr   = free_head_q;
        nl_we      = 1'b1;
        nl_waddr   = free_head_q;
        nl_wdata   = free_head_q;
        cur_d      = free_head_q;
        count_d    = count_q + CW'(1);
        res_st_d   = ST_NEW;
        res_slot_d = free_head_q;
        if (prev_ok_q) begin
          state_d = S_LINKP;
        end else begin
          hd_we     = 1'b1;
          hd_wvalid = 1'b1;
          hd_wnode  = free_head_q;
          state_d   = S_FIN;
        end
      end
      S_LINKP: begin
        nl_we    = 1'b1;
        nl_waddr = prev_q;
        nl_wdata = cur_q;
        state_d  = S_FIN;
      end
      S_POP2: begin
        nl_we        = 1'b1;
        nl_waddr     = cur_q;
        nl_wdata     = free_valid_q ? free_head_q : cur_q;
        free_head_d  = cur_q;
        free_valid_d = 1'b1;
        if (count_q != '0) begin
          count_d = count_q - CW'(1);
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_val_d   = VAL_W'(res_val_q);
          out_len_d   = res_len_q;
          out_slot_d  = SLOT_W'(res_slot_q);
          out_cnt_d   = CNT_W'(count_q);
          clr_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      op_q         <= '0;
      bkt_q        <= '0;
      key_q        <= '0;
      val_q        <= '0;
      len_q        <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      prev_ok_q    <= 1'b0;
      found_q      <= 1'b0;
      steps_q      <= '0;
      free_head_q  <= NW'(POOL_NODES - 1);
      free_valid_q <= 1'b1;
      count_q      <= '0;
      sweep_q      <= '0;
      clr_q        <= 1'b0;
      res_st_q     <= ST_NOTFOUND;
      res_val_q    <= '0;
      res_len_q    <= '0;
      res_slot_q   <= '0;
      out_valid_q  <= 1'b0;
      out_st_q     <= '0;
      out_val_q    <= '0;
      out_len_q    <= '0;
      out_slot_q   <= '0;
      out_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      bkt_q        <= bkt_d;
      key_q        <= key_d;
      val_q        <= val_d;
      len_q        <= len_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      prev_ok_q    <= prev_ok_d;
      found_q      <= found_d;
      steps_q      <= steps_d;
      free_head_q  <= free_head_d;
      free_valid_q <= free_valid_d;
      count_q      <= count_d;
      sweep_q      <= sweep_d;
      clr_q        <= clr_d;
      res_st_q     <= res_st_d;
      res_val_q    <= res_val_d;
      res_len_q    <= res_len_d;
      res_slot_q   <= res_slot_d;
      out_valid_q  <= out_valid_d;
      out_st_q     <= out_st_d;
      out_val_q    <= out_val_d;
      out_len_q    <= out_len_d;
      out_slot_q   <= out_slot_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_value_o    = out_val_q;
  assign out_length_o   = out_len_q;
  assign node_slot_o    = out_slot_q;
  assign stored_count_o = out_cnt_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(POOL_NODES))
    else $error("key count exceeds the pool size");

  a_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !free_valid_q |-> count_q == CW'(POOL_NODES))
    else $error("free list empty while nodes remain unused");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> steps_q < CW'(POOL_NODES))
    else $error("chain walk ran past the pool size");
`endif

endmodule
